@@ rtl/dsfp_pkg.sv @@
// Shared types and constants for the decimal string to fixed-point converter.
// No dependencies; imported by every module of the block.
package dsfp_pkg;

  localparam logic [7:0]  CH_DOT          = 8'h2E;
  localparam logic [7:0]  CH_ZERO         = 8'h30;
  localparam logic [7:0]  CH_NINE         = 8'h39;
  localparam logic [7:0]  FRAC_SAT        = 8'hFF;
  localparam logic [7:0]  SCALE_DIGITS    = 8'd2;
  localparam logic [63:0] MAX_VALUE_RESET = 64'h0000_FFFF_FFFF_FFFF;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd1;

  localparam int OUT_W = 80;

  // Parser state at the final character of a string.
  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  frac;
    logic        bad;
  } scan_t;

  typedef struct packed {
    logic [3:0]  byte_length;
    logic        ok;
    logic [7:0]  frac;
    logic [63:0] value;
  } result_t;

endpackage

@@ rtl/dsfp_scan.sv @@
// Character parser: digit accumulator, dot tracking and fraction count.
// Depends on dsfp_pkg.
module dsfp_scan
  import dsfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       last,
  output scan_t      done
);

  logic [63:0] accum, accum_next;
  logic        dot_seen, dot_seen_next;
  logic [7:0]  after_dot, after_dot_next;
  logic        bad_char, bad_char_next;
  logic        is_digit;

  always_comb begin
    is_digit       = (ch >= CH_ZERO) && (ch <= CH_NINE);
    after_dot_next = (dot_seen && after_dot != FRAC_SAT) ? after_dot + 8'd1 : after_dot;
    dot_seen_next  = dot_seen;
    bad_char_next  = bad_char;
    accum_next     = accum;
    if (ch == CH_DOT) begin
      dot_seen_next = 1'b1;
      if (dot_seen) bad_char_next = 1'b1;
    end else if (is_digit) begin
      // accum * 10 + digit as two shifts and two adds
      accum_next = {accum[60:0], 3'b000} + {accum[62:0], 1'b0} + {60'd0, ch[3:0]};
    end else begin
      bad_char_next = 1'b1;
    end
    done = '{value: accum_next, frac: after_dot_next, bad: bad_char_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum     <= '0;
      dot_seen  <= 1'b0;
      after_dot <= '0;
      bad_char  <= 1'b0;
    end else if (take) begin
      if (last) begin
        accum     <= '0;
        dot_seen  <= 1'b0;
        after_dot <= '0;
        bad_char  <= 1'b0;
      end else begin
        accum     <= accum_next;
        dot_seen  <= dot_seen_next;
        after_dot <= after_dot_next;
        bad_char  <= bad_char_next;
      end
    end
  end

endmodule

@@ rtl/dsfp_limit.sv @@
// Limit check, rejection zeroing and minimal byte length of the result.
// Depends on dsfp_pkg.
module dsfp_limit
  import dsfp_pkg::*;
(
  input  logic [63:0] value,
  input  logic [7:0]  frac,
  input  logic        ok_in,
  input  logic        mode,
  input  logic [63:0] max_value,
  output result_t     res
);

  logic       ok;
  logic [3:0] len;

  always_comb begin
    ok = ok_in && !(mode && (value > max_value));
    res.value = ok ? value : 64'd0;
    res.frac  = ok ? frac : 8'd0;
    res.ok    = ok;
    len = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (res.value[8*i +: 8] != 8'd0) len = 4'(i + 1);
    end
    res.byte_length = len;
  end

endmodule

@@ rtl/decimal_string_to_fixed_point_top.sv @@
// Decimal string to fixed-point converter, one character per transfer.
// Throughput: one character per cycle, set by the x10 accumulate loop; a final character
// waits out stalls; its result passes the snapshot, scaled-value and output registers.
// Synchronous active-high reset clears the parser, the pipeline and sets
// mode to 0 and max_value to 0xFFFFFFFFFFFF.
// Depends on dsfp_pkg, dsfp_scan, dsfp_limit.
module decimal_string_to_fixed_point_top
  import dsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] ch
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [63:0] result_value, [71:64] fraction_digits,
                                          // [72] ok, [76:73] byte_length, [79:77] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic        mode;
  logic [63:0] max_value;

  // input register
  logic       v0;
  logic [7:0] ch0;
  logic       last0;
  // final-character snapshot
  logic        v1;
  scan_t       fin;
  logic        fin_mode;
  logic [63:0] fin_max;
  // scaled value
  logic        v2;
  logic [63:0] sc_value;
  logic [7:0]  sc_frac;
  logic        sc_ok;
  logic        sc_mode;
  logic [63:0] sc_max;
  // output register
  logic        v3;
  result_t     res;

  logic    rdy1, rdy2, rdy3, take;
  scan_t   done;
  result_t res_next;
  logic [63:0] scaled;
  logic [7:0]  frac_next;
  logic        ok_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODE)      mode      <= cfg_data[0];
      if (cfg_index == REG_MAX_VALUE) max_value <= cfg_data;
    end
  end

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign take     = v0 && (!last0 || rdy1);
  assign s_tready = !v0 || take;

  dsfp_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (ch0),
    .last (last0),
    .done (done)
  );

  always_comb begin
    scaled    = fin.value;
    ok_next   = !fin.bad;
    frac_next = fin.frac;
    if (fin_mode) begin
      frac_next = 8'd0;
      if (fin.frac > SCALE_DIGITS) begin
        ok_next = 1'b0;
      end else if (fin.frac == 8'd1) begin
        scaled = {fin.value[60:0], 3'b000} + {fin.value[62:0], 1'b0};
      end else if (fin.frac == 8'd0) begin
        scaled = {fin.value[57:0], 6'd0} + {fin.value[58:0], 5'd0}
               + {fin.value[61:0], 2'b00};
      end
    end
  end

  dsfp_limit u_limit (
    .value     (sc_value),
    .frac      (sc_frac),
    .ok_in     (sc_ok),
    .mode      (sc_mode),
    .max_value (sc_max),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) v0 <= s_tvalid;
      if (rdy1)     v1 <= take && last0;
      if (rdy2)     v2 <= v1;
      if (rdy3)     v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ch0   <= s_tdata;
      last0 <= s_tlast;
    end
    if (rdy1) begin
      fin      <= done;
      fin_mode <= mode;
      fin_max  <= max_value;
    end
    if (rdy2) begin
      sc_value <= scaled;
      sc_frac  <= frac_next;
      sc_ok    <= ok_next;
      sc_mode  <= fin_mode;
      sc_max   <= fin_max;
    end
    if (rdy3) res <= res_next;
  end

  assign m_tvalid = v3;
  assign m_tdata  = {3'b000, res.byte_length, res.ok, res.frac, res.value};

endmodule

@@ tb/dsfp_result_checker.sv @@
// Checker for the decimal string converter: watches the character, result and register channels.
// Keeps its own copy of the parse state, predicts each result and compares it field by field.
// Depends on dsfp_pkg.
module dsfp_result_checker
  import dsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   errors,
  output int                   outstanding,
  output int                   results_checked,
  output int                   results_rejected
);

  logic        scaled_mode;
  logic [63:0] value_limit;

  logic [63:0] accum;
  logic        dot_seen;
  logic [7:0]  after_dot;
  logic        bad_char;

  result_t pending_results[$];

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    logic [63:0] val;
    logic [7:0]  frac;
    logic        good;
    logic [3:0]  nbytes;
    int          k;
    result_t     want;
    result_t     seen;
    if (rst) begin
      scaled_mode      = 1'b0;
      value_limit      = MAX_VALUE_RESET;
      accum            = '0;
      dot_seen         = 1'b0;
      after_dot        = '0;
      bad_char         = 1'b0;
      errors           = 0;
      results_checked  = 0;
      results_rejected = 0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:      scaled_mode = cfg_data[0];
          REG_MAX_VALUE: value_limit = cfg_data;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        // the count includes the current character once a dot has been seen
        if (dot_seen && after_dot != FRAC_SAT)
          after_dot++;
        if (s_tdata == CH_DOT) begin
          if (dot_seen)
            bad_char = 1'b1;
          dot_seen = 1'b1;
        end else if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
          accum = accum * 64'd10 + 64'(s_tdata - CH_ZERO);
        end else begin
          bad_char = 1'b1;
        end

        if (s_tlast) begin
          val  = accum;
          frac = after_dot;
          good = !bad_char;
          if (scaled_mode) begin
            if (frac > SCALE_DIGITS)
              good = 1'b0;
            else if (frac == 8'd1)
              val = val * 64'd10;
            else if (frac == 8'd0)
              val = val * 64'd100;
            frac = '0;
            if (good && val > value_limit)
              good = 1'b0;
          end
          if (!good) begin
            val  = '0;
            frac = '0;
          end
          nbytes = 4'd1;
          for (k = 1; k < 8; k++)
            if ((val >> (8 * k)) != 64'd0)
              nbytes = 4'(k + 1);
          want.value       = val;
          want.frac        = frac;
          want.ok          = good;
          want.byte_length = nbytes;
          pending_results.push_back(want);
          accum     = '0;
          dot_seen  = 1'b0;
          after_dot = '0;
          bad_char  = 1'b0;
        end
      end

      if (m_tvalid && m_tready) begin
        seen = m_tdata[76:0];
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected result, expected none, actual value %0h ok %0b",
                     $time, seen.value, seen.ok);
        end else begin
          want = pending_results.pop_front();
          check_field("result_value", want.value, seen.value);
          check_field("fraction_digits", 64'(want.frac), 64'(seen.frac));
          check_field("ok", 64'(want.ok), 64'(seen.ok));
          check_field("byte_length", 64'(want.byte_length), 64'(seen.byte_length));
          check_field("pad bits", 64'd0, 64'(m_tdata[OUT_W-1:77]));
        end
        results_checked++;
        if (!seen.ok)
          results_rejected++;
      end

      outstanding <= pending_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the decimal string converter: clock, reset, character and register stimulus.
// Checking is done by dsfp_result_checker; depends on dsfp_pkg and the converter RTL.
module tb
  import dsfp_pkg::*;
();

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data  = '0;

  int errors;
  int outstanding;
  int results_checked;
  int results_rejected;

  logic [7:0] text[$];
  int burst_left    = 0;
  int chars_sent    = 0;
  int strings_sent  = 0;
  int settings_used = 0;
  int rx_left       = 0;
  int rx_style      = 0;

  decimal_string_to_fixed_point_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dsfp_result_checker result_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .results_rejected (results_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  // receiver: always ready, coin flip, or mostly stalled, switching between them at random
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_left  = $urandom_range(16, 200);
    end
    rx_left--;
    case (rx_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // sends the characters in text, last flag on the final one, in bursts with idle gaps
  task automatic send_text();
    int gap;
    for (int i = 0; i < text.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      s_tvalid <= 1'b1;
      s_tdata  <= text[i];
      s_tlast  <= (i == text.size() - 1);
      do @(posedge clk); while (!s_tready);
      chars_sent++;
    end
    strings_sent++;
  endtask

  task automatic send_literal(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++)
      text.push_back(s[i]);
    send_text();
  endtask

  // lets every pending result drain, then waits for the pipeline to settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic scaled, input logic [63:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {63'd0, scaled};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MAX_VALUE;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic add_digits(input int n);
    repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly well-formed numbers with random content, some broken, some pure noise
  task automatic make_text(input logic scaled);
    int pick;
    int r;
    int int_len;
    int frac_len;
    int pos;
    bit has_dot;
    text.delete();
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      r = $urandom_range(0, 19);
      if (r < 11)
        int_len = $urandom_range(0, 4);
      else if (r < 16)
        int_len = $urandom_range(5, 12);
      else
        int_len = $urandom_range(13, 22);
      has_dot = ($urandom_range(0, 2) != 0);
      if (scaled)
        frac_len = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
      else
        frac_len = $urandom_range(0, 8);
      if (int_len == 0 && !has_dot)
        int_len = 1;
      add_digits(int_len);
      if (has_dot) begin
        text.push_back(CH_DOT);
        add_digits(frac_len);
      end
      if (pick >= 70) begin
        pos = $urandom_range(0, text.size() - 1);
        if ($urandom_range(0, 1) != 0)
          text[pos] = 8'($urandom_range(0, 255));
        else
          text.insert(pos, CH_DOT);
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(0, 9);
        if (r < 5)
          text.push_back(8'($urandom_range(0, 255)));
        else if (r < 8)
          text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        else
          text.push_back(CH_DOT);
      end
    end
  endtask

  initial begin
    logic        scaled;
    logic [63:0] limit;
    int          phase_chars;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: dot placement, second dot, bad characters
    send_literal("0");
    send_literal(".");
    send_literal(".5");
    send_literal("12.");
    send_literal("1.2.3");
    text.delete();
    text.push_back(8'hFF);
    text.push_back("3");
    send_text();
    text.delete();
    text.push_back(8'h00);
    send_text();
    wait_idle();

    // scaled: whole, one decimal, too many decimals
    set_config(1'b1, MAX_VALUE_RESET);
    send_literal("7");
    send_literal("3.1");
    send_literal("1.234");
    wait_idle();

    // scaled with a zero limit: only zero passes
    set_config(1'b1, 64'd0);
    send_literal("0");
    send_literal("1");
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin scaled = 1'b0; limit = {$urandom, $urandom}; end
        1:       begin scaled = 1'b1; limit = MAX_VALUE_RESET; end
        2:       begin scaled = 1'b1; limit = '1; end
        3:       begin scaled = 1'b1; limit = 64'($urandom_range(0, 200000)); end
        4:       begin scaled = 1'b0; limit = '0; end
        5:       begin scaled = 1'b1; limit = '0; end
        6:       begin scaled = 1'b1; limit = {$urandom, $urandom}; end
        default: begin scaled = 1'b1; limit = 64'd99999; end
      endcase
      set_config(scaled, limit);
      phase_chars = 0;
      if (p == 0) begin
        // long fraction drives the digit counter into saturation
        text.delete();
        text.push_back("1");
        text.push_back(CH_DOT);
        add_digits(300);
        phase_chars += text.size();
        send_text();
      end
      while (phase_chars < 120) begin
        make_text(scaled);
        phase_chars += text.size();
        send_text();
      end
      wait_idle();
    end

    $display("Sent %0d characters in %0d strings under %0d register settings.",
             chars_sent, strings_sent, settings_used);
    $display("Checked %0d results, %0d of them rejected strings; %0d mismatches.",
             results_checked, results_rejected, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
